>>> sv/rcw_pkg.sv
// Shared types and constants for the RTMP chunk writer.
// Holds the microcode word layout, byte selector codes and the item record.
// No dependencies.
package rcw_pkg;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // Entry points of the microcode program.
    localparam upc_t PC_TYPE0   = 5'd0;
    localparam upc_t PC_EXT_TS  = 5'd12;
    localparam upc_t PC_PAYLOAD = 5'd16;
    localparam upc_t PC_CONT    = 5'd17;

    localparam logic [31:0] TS_ESCAPE        = 32'h00FF_FFFF;
    localparam logic [23:0] FILL_MAX         = 24'hFF_FFFF;
    localparam logic [23:0] CHUNK_SIZE_RESET = 24'd128;
    localparam logic [1:0]  FMT_FULL         = 2'd0;
    localparam logic [1:0]  FMT_CONT         = 2'd3;

    // Register index decoded from paddr[2].
    localparam logic REG_CHUNK_SIZE = 1'b0;

    typedef enum logic [4:0] {
        SEL_CSID_FULL,
        SEL_TS24_H,
        SEL_TS24_M,
        SEL_TS24_L,
        SEL_LEN_H,
        SEL_LEN_M,
        SEL_LEN_L,
        SEL_MTYPE,
        SEL_MSID_0,
        SEL_MSID_1,
        SEL_MSID_2,
        SEL_MSID_3,
        SEL_TS_3,
        SEL_TS_2,
        SEL_TS_1,
        SEL_TS_0,
        SEL_CSID_CONT,
        SEL_PAYLOAD
    } byte_sel_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_SKIP_EXT,
        SEQ_GOTO,
        SEQ_END
    } seq_op_t;

    typedef struct packed {
        byte_sel_t sel;
        logic      is_hdr;
        logic      last;
        seq_op_t   op;
        upc_t      target;
    } ucode_t;

    typedef struct packed {
        logic [23:0] mlen;
        logic [31:0] ts;
        logic [31:0] msid;
        logic [7:0]  mtype;
        logic [5:0]  csid;
        logic [7:0]  payload;
    } msg_t;

endpackage

>>> sv/rcw_ucode_rom.sv
// Microcode program of the chunk writer: one control word per step.
// Depends on rcw_pkg.
module rcw_ucode_rom (
    input  rcw_pkg::upc_t   pc,
    output rcw_pkg::ucode_t ctrl
);

    always_comb begin
        unique case (pc)
            5'd0:  ctrl = '{rcw_pkg::SEL_CSID_FULL, 1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd1:  ctrl = '{rcw_pkg::SEL_TS24_H,    1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd2:  ctrl = '{rcw_pkg::SEL_TS24_M,    1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd3:  ctrl = '{rcw_pkg::SEL_TS24_L,    1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd4:  ctrl = '{rcw_pkg::SEL_LEN_H,     1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd5:  ctrl = '{rcw_pkg::SEL_LEN_M,     1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd6:  ctrl = '{rcw_pkg::SEL_LEN_L,     1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd7:  ctrl = '{rcw_pkg::SEL_MTYPE,     1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd8:  ctrl = '{rcw_pkg::SEL_MSID_0,    1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd9:  ctrl = '{rcw_pkg::SEL_MSID_1,    1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd10: ctrl = '{rcw_pkg::SEL_MSID_2,    1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            // Skip the extended timestamp unless the timestamp escaped.
            5'd11: ctrl = '{rcw_pkg::SEL_MSID_3,    1'b1, 1'b0, rcw_pkg::SEQ_SKIP_EXT,
                            rcw_pkg::PC_PAYLOAD};
            5'd12: ctrl = '{rcw_pkg::SEL_TS_3,      1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd13: ctrl = '{rcw_pkg::SEL_TS_2,      1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd14: ctrl = '{rcw_pkg::SEL_TS_1,      1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd15: ctrl = '{rcw_pkg::SEL_TS_0,      1'b1, 1'b0, rcw_pkg::SEQ_NEXT, '0};
            5'd16: ctrl = '{rcw_pkg::SEL_PAYLOAD,   1'b0, 1'b1, rcw_pkg::SEQ_END, '0};
            5'd17: ctrl = '{rcw_pkg::SEL_CSID_CONT, 1'b1, 1'b0, rcw_pkg::SEQ_GOTO,
                            rcw_pkg::PC_PAYLOAD};
            default: ctrl = '{rcw_pkg::SEL_PAYLOAD, 1'b0, 1'b1, rcw_pkg::SEQ_END, '0};
        endcase
    end

endmodule

>>> sv/rcw_sequencer.sv
// Step counter of the chunk writer: picks the entry point, follows jumps,
// and keeps the chunk fill count. Depends on rcw_pkg.
module rcw_sequencer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            item_accept,
    input  logic            item_first,
    input  logic [23:0]     chunk_size,
    input  logic            step_fire,
    input  logic            ext_ts,
    input  rcw_pkg::ucode_t ctrl,
    output rcw_pkg::upc_t   pc,
    output logic            busy,
    output logic            item_ready
);

    rcw_pkg::upc_t pc_reg, pc_next, start_pc;
    logic          busy_reg, busy_next;
    logic [23:0]   fill_reg, fill_next;
    logic          chunk_full;

    assign chunk_full = fill_reg >= chunk_size;
    assign pc         = pc_reg;
    assign busy       = busy_reg;
    // A new item may enter on the step that finishes the current one.
    assign item_ready = !busy_reg || (step_fire && ctrl.op == rcw_pkg::SEQ_END);

    always_comb begin
        priority if (item_first) begin
            start_pc = rcw_pkg::PC_TYPE0;
        end else if (chunk_full) begin
            start_pc = rcw_pkg::PC_CONT;
        end else begin
            start_pc = rcw_pkg::PC_PAYLOAD;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (item_accept) begin
            priority if (item_first || chunk_full) begin
                fill_next = 24'd1;
            end else if (fill_reg != rcw_pkg::FILL_MAX) begin
                fill_next = fill_reg + 24'd1;
            end
        end
    end

    always_comb begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (step_fire) begin
            unique case (ctrl.op)
                rcw_pkg::SEQ_NEXT:     pc_next = pc_reg + 5'd1;
                rcw_pkg::SEQ_SKIP_EXT: pc_next = ext_ts ? pc_reg + 5'd1 : ctrl.target;
                rcw_pkg::SEQ_GOTO:     pc_next = ctrl.target;
                rcw_pkg::SEQ_END:      busy_next = 1'b0;
                default:               busy_next = 1'b0;
            endcase
        end
        if (item_accept) begin
            pc_next   = start_pc;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= rcw_pkg::PC_TYPE0;
            busy_reg <= 1'b0;
            fill_reg <= '0;
        end else begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            fill_reg <= fill_next;
        end
    end

endmodule

>>> sv/rcw_datapath.sv
// Datapath of the chunk writer: holds the current item and selects the
// byte that the control word names. Depends on rcw_pkg.
module rcw_datapath (
    input  logic              aclk,
    input  logic              item_accept,
    input  rcw_pkg::msg_t     item,
    input  rcw_pkg::byte_sel_t sel,
    output logic [7:0]        byte_out,
    output logic              ext_ts
);

    rcw_pkg::msg_t item_reg;
    logic [23:0]   ts24;

    always_ff @(posedge aclk) begin
        if (item_accept) begin
            item_reg <= item;
        end
    end

    assign ext_ts = item_reg.ts >= rcw_pkg::TS_ESCAPE;
    assign ts24   = ext_ts ? rcw_pkg::TS_ESCAPE[23:0] : item_reg.ts[23:0];

    always_comb begin
        unique case (sel)
            rcw_pkg::SEL_CSID_FULL: byte_out = {rcw_pkg::FMT_FULL, item_reg.csid};
            rcw_pkg::SEL_TS24_H:    byte_out = ts24[23:16];
            rcw_pkg::SEL_TS24_M:    byte_out = ts24[15:8];
            rcw_pkg::SEL_TS24_L:    byte_out = ts24[7:0];
            rcw_pkg::SEL_LEN_H:     byte_out = item_reg.mlen[23:16];
            rcw_pkg::SEL_LEN_M:     byte_out = item_reg.mlen[15:8];
            rcw_pkg::SEL_LEN_L:     byte_out = item_reg.mlen[7:0];
            rcw_pkg::SEL_MTYPE:     byte_out = item_reg.mtype;
            rcw_pkg::SEL_MSID_0:    byte_out = item_reg.msid[7:0];
            rcw_pkg::SEL_MSID_1:    byte_out = item_reg.msid[15:8];
            rcw_pkg::SEL_MSID_2:    byte_out = item_reg.msid[23:16];
            rcw_pkg::SEL_MSID_3:    byte_out = item_reg.msid[31:24];
            rcw_pkg::SEL_TS_3:      byte_out = item_reg.ts[31:24];
            rcw_pkg::SEL_TS_2:      byte_out = item_reg.ts[23:16];
            rcw_pkg::SEL_TS_1:      byte_out = item_reg.ts[15:8];
            rcw_pkg::SEL_TS_0:      byte_out = item_reg.ts[7:0];
            rcw_pkg::SEL_CSID_CONT: byte_out = {rcw_pkg::FMT_CONT, item_reg.csid};
            rcw_pkg::SEL_PAYLOAD:   byte_out = item_reg.payload;
            default:                byte_out = item_reg.payload;
        endcase
    end

endmodule

>>> sv/rtmp_chunk_writer_unit.sv
// RTMP chunk writer top level. An accepted input word is held in the sequencer and datapath
// registers, and its first output word is then registered at the output; one word leaves per
// cycle while m_tready is high, one per microcode step. An item is the payload byte alone, after
// a type-3 header, after a type-0 header, or after a type-0 header with extended timestamp; the
// next item enters on the last step of the current one. aresetn is synchronous, active low: it
// clears the sequencer, the chunk fill count and the output valid, and sets chunk_size to 128.
module rtmp_chunk_writer_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // payload_byte[7:0], csid[13:8], message_type[21:14],
    // message_stream_id[53:22], timestamp[85:54], message_length[109:86], zero pad
    input  logic [111:0] s_tdata,
    // first_byte[0]
    input  logic [0:0]   s_tuser,
    // Output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_byte[7:0]
    output logic [7:0]   m_tdata,
    // is_header[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    logic [23:0]     chunk_size_reg, chunk_size_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [7:0]      m_tdata_reg;
    logic            m_tuser_reg, m_tlast_reg;
    logic            cfg_write, item_accept, step_fire, busy, ext_ts, item_ready;
    logic [7:0]      byte_out;
    rcw_pkg::upc_t   pc;
    rcw_pkg::ucode_t ctrl;
    rcw_pkg::msg_t   item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == rcw_pkg::REG_CHUNK_SIZE) ? {8'd0, chunk_size_reg} : 32'd0;

    always_comb begin
        chunk_size_next = chunk_size_reg;
        if (cfg_write && paddr[2] == rcw_pkg::REG_CHUNK_SIZE) begin
            chunk_size_next = pwdata[23:0];
        end
    end

    assign item = '{mlen:    s_tdata[109:86],
                    ts:      s_tdata[85:54],
                    msid:    s_tdata[53:22],
                    mtype:   s_tdata[21:14],
                    csid:    s_tdata[13:8],
                    payload: s_tdata[7:0]};

    assign s_tready    = item_ready;
    assign item_accept = s_tvalid && item_ready;
    assign step_fire   = busy && (!m_tvalid_reg || m_tready);

    rcw_ucode_rom u_rom (
        .pc   (pc),
        .ctrl (ctrl)
    );

    rcw_sequencer u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (item_accept),
        .item_first  (s_tuser[0]),
        .chunk_size  (chunk_size_reg),
        .step_fire   (step_fire),
        .ext_ts      (ext_ts),
        .ctrl        (ctrl),
        .pc          (pc),
        .busy        (busy),
        .item_ready  (item_ready)
    );

    rcw_datapath u_dp (
        .aclk        (aclk),
        .item_accept (item_accept),
        .item        (item),
        .sel         (ctrl.sel),
        .byte_out    (byte_out),
        .ext_ts      (ext_ts)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (step_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg <= rcw_pkg::CHUNK_SIZE_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            chunk_size_reg <= chunk_size_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            m_tdata_reg <= byte_out;
            m_tuser_reg <= ctrl.is_hdr;
            m_tlast_reg <= ctrl.last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

>>> sv/rcw_checker.sv
// Port-level checks for the RTMP chunk writer, bound to the top level.
// Depends only on the ports of rtmp_chunk_writer_unit.
module rcw_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [7:0]   m_tdata,
    input logic [0:0]   m_tuser,
    input logic         m_tlast
);

    // The closing word of an item is always the payload byte.
    a_last_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser[0])
        else $error("last word of an item is marked as header");

    // Every payload byte closes its item.
    a_payload_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("payload word without last flag");

    // Within an item the words follow without gaps.
    a_no_gap_in_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside the words of one item");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind rtmp_chunk_writer_unit rcw_checker u_rcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
